// ===== rtl/cild_pkg.sv =====
// cild_pkg: shared types and character codes for the c integer literal decoder
// used by cild_lex, cild_classify and c_integer_literal_decoder; no dependencies
package cild_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_XSEEN  = 3'd2,
    PH_DIGITS = 3'd3,
    PH_SUFFIX = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef enum logic [2:0] {
    T_INT    = 3'd0,
    T_UINT   = 3'd1,
    T_LONG   = 3'd2,
    T_ULONG  = 3'd3,
    T_LLONG  = 3'd4,
    T_ULLONG = 3'd5
  } ctype_t;

  // finished token handed from the lexer to the classifier
  typedef struct packed {
    logic [63:0] acc;
    base_t       base;
    logic        ovf;
    logic        uns;
    logic        lng;
    logic        llng;
  } tok_t;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_UU = 8'h55;
  localparam logic [7:0] CH_LL = 8'h6c;
  localparam logic [7:0] CH_UL = 8'h4c;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned WIDTH_W = 7;
  localparam int unsigned OUT_W   = 72;

  localparam logic [WIDTH_W-1:0] INT_W_RST  = 7'd32;
  localparam logic [WIDTH_W-1:0] LONG_W_RST = 7'd64;
  localparam logic [WIDTH_W-1:0] INT_W_MIN  = 7'd16;
  localparam logic [WIDTH_W-1:0] LONG_W_MIN = 7'd32;
  localparam logic [WIDTH_W-1:0] W_MAX      = 7'd64;

  localparam logic [0:0] REG_INT_W  = 1'b0;
  localparam logic [0:0] REG_LONG_W = 1'b1;

endpackage

// ===== rtl/cild_lex.sv =====
// cild_lex: per-character token scanner with accumulator and suffix flags,
// plus the register that holds a finished token; depends on cild_pkg
module cild_lex
  import cild_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  logic [7:0] item_char,
  input  logic       item_last,
  output logic       item_ready,
  output logic       snap_valid,
  output tok_t       snap,
  input  logic       snap_ready
);

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c inside {[CH_0:CH_9]}) begin
      d = 5'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = 5'(c - CH_LA + 8'd10);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = 5'(c - CH_UA + 8'd10);
    end
    return d;
  endfunction

  phase_t      phase_r, phase_nxt;
  base_t       base_r, base_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic        uns_r, uns_nxt;
  logic        lng_r, lng_nxt;
  logic        llng_r, llng_nxt;
  logic [7:0]  prev_r;
  logic        snap_valid_r, snap_valid_nxt;
  tok_t        snap_r;

  logic [4:0]  dig;
  logic [4:0]  lim;
  logic [67:0] prod;
  logic [67:0] madd;
  logic        add_en;
  logic        sfx_en;
  logic        slot_free;
  logic        take;

  assign dig = digit_of(item_char);

  // base times accumulator in 68 bits, so any carry past bit 63 is overflow
  always_comb begin
    case (base_r)
      BASE_HEX: prod = {acc_r, 4'b0};
      BASE_OCT: prod = {1'b0, acc_r, 3'b0};
      default:  prod = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0};
    endcase
  end

  assign madd = prod + {64'b0, dig[3:0]};

  always_comb begin
    case (base_r)
      BASE_HEX: lim = 5'd16;
      BASE_OCT: lim = 5'd8;
      default:  lim = 5'd10;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    add_en    = 1'b0;
    sfx_en    = 1'b0;
    case (phase_r)
      PH_START: begin
        if (item_char == CH_0) begin
          base_nxt  = BASE_OCT;
          phase_nxt = PH_ZERO;
        end else if (dig < 5'd10) begin
          base_nxt  = BASE_DEC;
          add_en    = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_SUFFIX;
          sfx_en    = 1'b1;
        end
      end
      PH_ZERO: begin
        if (item_char == CH_LX || item_char == CH_UX) begin
          base_nxt  = BASE_HEX;
          phase_nxt = PH_XSEEN;
        end else if (dig < 5'd8) begin
          add_en    = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_SUFFIX;
          sfx_en    = 1'b1;
        end
      end
      PH_XSEEN: begin
        if (dig < 5'd16) begin
          add_en    = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_SUFFIX;
          sfx_en    = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (dig < lim) begin
          add_en = 1'b1;
        end else begin
          phase_nxt = PH_SUFFIX;
          sfx_en    = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_SUFFIX;
        sfx_en    = 1'b1;
      end
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    uns_nxt  = uns_r;
    lng_nxt  = lng_r;
    llng_nxt = llng_r;
    if (add_en && !ovf_r) begin
      if (|madd[67:64]) begin
        ovf_nxt = 1'b1;
        acc_nxt = '1;
      end else begin
        acc_nxt = madd[63:0];
      end
    end
    if (sfx_en) begin
      if (item_char == CH_LU || item_char == CH_UU) uns_nxt = 1'b1;
      if (item_char == CH_LL || item_char == CH_UL) lng_nxt = 1'b1;
      if ((item_char == CH_LL && prev_r == CH_LL) ||
          (item_char == CH_UL && prev_r == CH_UL)) begin
        llng_nxt = 1'b1;
      end
    end
  end

  // a last character needs room in the token register, others never stall
  assign slot_free      = !snap_valid_r || snap_ready;
  assign item_ready     = !item_last || slot_free;
  assign take           = item_valid && item_ready;
  assign snap_valid_nxt = take && item_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      base_r  <= BASE_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      uns_r   <= 1'b0;
      lng_r   <= 1'b0;
      llng_r  <= 1'b0;
      prev_r  <= '0;
    end else if (take) begin
      if (item_last) begin
        phase_r <= PH_START;
        base_r  <= BASE_DEC;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
        uns_r   <= 1'b0;
        lng_r   <= 1'b0;
        llng_r  <= 1'b0;
        prev_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        uns_r   <= uns_nxt;
        lng_r   <= lng_nxt;
        llng_r  <= llng_nxt;
        prev_r  <= item_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (slot_free) begin
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid_nxt) begin
      snap_r.acc  <= acc_nxt;
      snap_r.base <= base_nxt;
      snap_r.ovf  <= ovf_nxt;
      snap_r.uns  <= uns_nxt;
      snap_r.lng  <= lng_nxt;
      snap_r.llng <= llng_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== rtl/cild_classify.sv =====
// cild_classify: picks the c type of a finished token from the suffix/base
// table and holds the result word for the output channel; depends on cild_pkg
module cild_classify
  import cild_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               snap_valid,
  input  tok_t               snap,
  output logic               snap_ready,
  input  logic [WIDTH_W-1:0] int_w,
  input  logic [WIDTH_W-1:0] long_w,
  output logic               out_valid,
  output logic [OUT_W-1:0]   out_word,
  input  logic               out_ready
);

  logic [WIDTH_W-1:0] iw;
  logic [WIDTH_W-1:0] lw;
  logic [63:0]        max_int;
  logic [63:0]        max_uint;
  logic [63:0]        max_long;
  logic [63:0]        max_ulong;
  logic               f_int, f_uint, f_long, f_ulong, f_llong;
  logic               plain;
  ctype_t             ty;
  logic               fits;
  logic               free;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_word_r, out_word_nxt;

  assign iw = (int_w < INT_W_MIN) ? INT_W_MIN : (int_w > W_MAX) ? W_MAX : int_w;
  assign lw = (long_w < LONG_W_MIN) ? LONG_W_MIN : (long_w > W_MAX) ? W_MAX : long_w;

  assign max_int   = {64{1'b1}} >> (7'd65 - iw);
  assign max_uint  = {64{1'b1}} >> (W_MAX - iw);
  assign max_long  = {64{1'b1}} >> (7'd65 - lw);
  assign max_ulong = {64{1'b1}} >> (W_MAX - lw);

  assign f_int   = snap.acc <= max_int;
  assign f_uint  = snap.acc <= max_uint;
  assign f_long  = snap.acc <= max_long;
  assign f_ulong = snap.acc <= max_ulong;
  assign f_llong = !snap.acc[63];
  assign plain   = !snap.lng && !snap.llng;

  // unsigned long long holds every value, so only signed decimal can miss
  always_comb begin
    ty   = T_INT;
    fits = 1'b1;
    if (snap.base == BASE_DEC) begin
      if (!snap.uns) begin
        if (plain && f_int) ty = T_INT;
        else if (!snap.llng && f_long) ty = T_LONG;
        else if (f_llong) ty = T_LLONG;
        else fits = 1'b0;
      end else begin
        if (plain && f_uint) ty = T_UINT;
        else if (!snap.llng && f_ulong) ty = T_ULONG;
        else ty = T_ULLONG;
      end
    end else begin
      if (plain && !snap.uns && f_int) ty = T_INT;
      else if (plain && f_uint) ty = T_UINT;
      else if (!snap.llng && !snap.uns && f_long) ty = T_LONG;
      else if (!snap.llng && f_ulong) ty = T_ULONG;
      else if (!snap.uns && f_llong) ty = T_LLONG;
      else ty = T_ULLONG;
    end
  end

  assign out_word_nxt = {3'b0, snap.ovf, fits, ty, snap.acc};

  assign free       = !out_valid_r || out_ready;
  assign snap_ready = free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && snap_valid) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/c_integer_literal_decoder.sv =====
// c_integer_literal_decoder: decodes the characters of a c integer literal
// into its value and type. channels: in_ takes one character per word, tlast
// on the final character of a token; out_ gives one word per token with the
// value, type code, fits flag and overflow flag; cfg_ is an apb port with
// int width at address 0 and long width at address 4 (7 bits each).
// a token's result word passes in turn through the input register, the
// lexer's token register and the classifier's output register once its last
// character is accepted. throughput: one character per cycle while in_tready
// is high; the accumulator update is a single multiply-add by 8, 10 or 16
// built from shifts and adds.
// when out_tready is low the output register holds its word, the token
// register can still take one more finished token, and characters that do
// not end a token keep flowing; in_tready drops only when a last character
// finds both registers full. reset clears the token state, the pipeline
// valid bits and sets the widths to 32 (int) and 64 (long). widths are
// clamped to 16..64 for int and 32..64 for long when the type is chosen.
// depends on cild_pkg, cild_lex and cild_classify
module c_integer_literal_decoder
  import cild_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,     // [7:0] character
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,    // [63:0] literal_value, [66:64] type_code,
                                         // [67] type_fits, [68] range_overflow
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic               s1_valid_r;
  logic [7:0]         s1_char_r;
  logic               s1_last_r;
  logic               lex_ready;
  logic               snap_valid;
  tok_t               snap;
  logic               snap_ready;
  logic [WIDTH_W-1:0] int_w_r;
  logic [WIDTH_W-1:0] long_w_r;
  logic               cfg_wr;

  assign in_tready = !s1_valid_r || lex_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_w_r  <= INT_W_RST;
      long_w_r <= LONG_W_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_INT_W) int_w_r <= cfg_pwdata[WIDTH_W-1:0];
      else long_w_r <= cfg_pwdata[WIDTH_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_INT_W) ? {25'b0, int_w_r} : {25'b0, long_w_r};

  cild_lex u_lex (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item_char  (s1_char_r),
    .item_last  (s1_last_r),
    .item_ready (lex_ready),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  cild_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .int_w      (int_w_r),
    .long_w     (long_w_r),
    .out_valid  (out_tvalid),
    .out_word   (out_tdata),
    .out_ready  (out_tready)
  );

  // no fitting type is always reported as int
  a_nofit_int: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[67]) |-> (out_tdata[66:64] == T_INT))
    else $error("unfitting literal not reported as int");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[68]) |-> (out_tdata[63:0] == {64{1'b1}}))
    else $error("overflowed literal not saturated");

  // input backpressure only comes from a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output stall");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[66:64] <= T_ULLONG))
    else $error("type code out of range");

endmodule
